// ===== rtl/core/rlmec_pkg.sv =====
// ----------------------------------------------------------------------------
// rlmec_pkg: shared types and constants for the RGB LED effect controller
// Holds the payload structs of both channels, the queue entry type and the
// mode, color and timing codes used by the front and back ends.
// ----------------------------------------------------------------------------
package rlmec_pkg;

  // Field widths fixed by the item formats.
  localparam int LEVEL_W  = 7;
  localparam int MODE_W   = 4;
  localparam int SAMPLE_W = 16;
  localparam int DELAY_W  = 6;
  localparam int MASK_W   = 3;
  localparam int COLOR_W  = 2;

  // Default depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_TOUCH_FLOOR = 1'b0;
  localparam logic [SAMPLE_W-1:0] TOUCH_FLOOR_RESET = 16'd10;

  // Item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_MODE = 1'b1;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_GLOW    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_GLOW_R  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_GLOW_G  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_GLOW_B  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_TOUCH   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_TOUCH_R = 4'd5;
  localparam logic [MODE_W-1:0] MODE_TOUCH_G = 4'd6;
  localparam logic [MODE_W-1:0] MODE_TOUCH_B = 4'd7;
  localparam logic [MODE_W-1:0] MODE_ACCEL   = 4'd8;

  // Glow color codes.
  localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd2;

  // Channel write masks.
  localparam logic [MASK_W-1:0] MASK_NONE  = 3'b000;
  localparam logic [MASK_W-1:0] MASK_RED   = 3'b001;
  localparam logic [MASK_W-1:0] MASK_GREEN = 3'b010;
  localparam logic [MASK_W-1:0] MASK_BLUE  = 3'b100;
  localparam logic [MASK_W-1:0] MASK_ALL   = 3'b111;

  // Levels and tick delays.
  localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 7'd100;
  localparam logic [LEVEL_W-1:0] TOUCH_PRESET = 7'd50;
  localparam logic [DELAY_W-1:0] DELAY_MODE   = 6'd0;
  localparam logic [DELAY_W-1:0] DELAY_GLOW   = 6'd10;
  localparam logic [DELAY_W-1:0] DELAY_TOUCH  = 6'd20;
  localparam logic [DELAY_W-1:0] DELAY_ACCEL  = 6'd50;

  // Input item.
  typedef struct packed {
    logic                       kind;
    logic [MODE_W-1:0]          new_mode;
    logic [SAMPLE_W-1:0]        touch_sample;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [MASK_W-1:0]  write_mask;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [DELAY_W-1:0] next_delay_ms;
  } out_item_t;

  // Classified item as it waits in the queue.
  typedef struct packed {
    logic                is_mode;
    logic [MODE_W-1:0]   new_mode;
    logic [SAMPLE_W-1:0] touch_raw;
    logic [LEVEL_W-1:0]  touch_pct;
    logic [LEVEL_W-1:0]  accel_x_pct;
    logic [LEVEL_W-1:0]  accel_y_pct;
    logic [LEVEL_W-1:0]  accel_z_pct;
  } op_t;

endpackage

// ===== rtl/core/rlmec_front.sv =====
// ----------------------------------------------------------------------------
// rlmec_front: input classification and sensor scaling
// Sorts each incoming item into a mode request or a tick and scales the
// touch and accelerometer samples to percents ahead of the queue.
// ----------------------------------------------------------------------------
module rlmec_front (
  input  rlmec_pkg::in_item_t item,
  output rlmec_pkg::op_t      op
);
  import rlmec_pkg::*;

  // Magnitude of a signed sample, clamped at 4096, scaled by 100/4096.
  function automatic logic [LEVEL_W-1:0] accel_pct(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W:0] mag;
    logic [12:0]       clamped;
    logic [19:0]       prod;
    mag = v[SAMPLE_W-1] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    clamped = (mag > 17'd4096) ? 13'd4096 : mag[12:0];
    prod = 20'(clamped) * 20'd100;
    return prod[18:12];
  endfunction

  // Sample clamped at 600, scaled by 100/600 = 1/6 through a reciprocal.
  // 10923/65536 is exact enough for every value up to 600.
  function automatic logic [LEVEL_W-1:0] touch_pct(input logic [SAMPLE_W-1:0] d);
    logic [9:0]  clamped;
    logic [23:0] prod;
    clamped = (d > 16'd600) ? 10'd600 : d[9:0];
    prod = 24'(clamped) * 24'd10923;
    return prod[22:16];
  endfunction

  // Classification and scaling.
  always_comb begin
    op.is_mode     = (item.kind == KIND_MODE);
    op.new_mode    = item.new_mode;
    op.touch_raw   = item.touch_sample;
    op.touch_pct   = touch_pct(item.touch_sample);
    op.accel_x_pct = accel_pct(item.accel_x);
    op.accel_y_pct = accel_pct(item.accel_y);
    op.accel_z_pct = accel_pct(item.accel_z);
  end

endmodule

// ===== rtl/core/rlmec_queue.sv =====
// ----------------------------------------------------------------------------
// rlmec_queue: small queue between front and back end
// A register-based FIFO that lets the front accept while the back stalls.
// ----------------------------------------------------------------------------
module rlmec_queue #(
  parameter int DEPTH = rlmec_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rlmec_pkg::op_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rlmec_pkg::op_t pop_data
);
  import rlmec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/rlmec_back.sv =====
// ----------------------------------------------------------------------------
// rlmec_back: mode state and effect execution
// Holds the current mode and the glow and touch state, carries out each
// queued transaction and registers the result for the output channel.
// ----------------------------------------------------------------------------
module rlmec_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rlmec_pkg::SAMPLE_W-1:0]   touch_floor,
  input  logic                             op_valid,
  output logic                             op_ready,
  input  rlmec_pkg::op_t                   op,
  output logic                             res_valid,
  input  logic                             res_ready,
  output rlmec_pkg::out_item_t             res
);
  import rlmec_pkg::*;

  logic [MODE_W-1:0]  current_mode, current_mode_next;
  logic [LEVEL_W-1:0] glow_level, glow_level_next;
  logic               glow_rising, glow_rising_next;
  logic [COLOR_W-1:0] glow_color, glow_color_next;
  logic [LEVEL_W-1:0] touch_level, touch_level_next;
  logic [LEVEL_W-1:0] step_level;
  logic               emit;
  logic               pop;
  out_item_t          res_next;

  // The back end takes a transaction whenever the output register is free.
  assign op_ready = !res_valid || res_ready;
  assign pop      = op_valid && op_ready;

  // Execution of one transaction.
  always_comb begin
    current_mode_next = current_mode;
    glow_level_next   = glow_level;
    glow_rising_next  = glow_rising;
    glow_color_next   = glow_color;
    touch_level_next  = touch_level;
    step_level        = '0;
    emit              = 1'b0;
    res_next          = '0;
    if (pop) begin
      if (op.is_mode) begin
        // A request for a different mode turns everything off.
        if (op.new_mode != current_mode) begin
          emit                = 1'b1;
          res_next.write_mask = MASK_ALL;
          res_next.next_delay_ms = DELAY_MODE;
          if (op.new_mode <= MODE_GLOW_B) begin
            glow_level_next   = '0;
            glow_rising_next  = 1'b1;
            current_mode_next = op.new_mode;
            case (op.new_mode)
              MODE_GLOW_R: glow_color_next = COLOR_RED;
              MODE_GLOW_B: glow_color_next = COLOR_BLUE;
              default:     glow_color_next = COLOR_GREEN;
            endcase
          end else if (op.new_mode <= MODE_TOUCH_B) begin
            touch_level_next  = TOUCH_PRESET;
            current_mode_next = op.new_mode;
          end else if (op.new_mode == MODE_ACCEL) begin
            current_mode_next = op.new_mode;
          end
        end
      end else if (current_mode == MODE_ACCEL) begin
        emit                   = 1'b1;
        res_next.write_mask    = MASK_ALL;
        res_next.red_level     = op.accel_x_pct;
        res_next.green_level   = op.accel_y_pct;
        res_next.blue_level    = op.accel_z_pct;
        res_next.next_delay_ms = DELAY_ACCEL;
      end else if (current_mode >= MODE_TOUCH && current_mode <= MODE_TOUCH_B) begin
        // Samples at or below the floor hold the last level.
        emit = 1'b1;
        if (op.touch_raw > touch_floor) begin
          touch_level_next = op.touch_pct;
        end
        case (current_mode)
          MODE_TOUCH_R: begin
            res_next.write_mask = MASK_RED;
            res_next.red_level  = touch_level_next;
          end
          MODE_TOUCH_G: begin
            res_next.write_mask  = MASK_GREEN;
            res_next.green_level = touch_level_next;
          end
          default: begin
            res_next.write_mask = MASK_BLUE;
            res_next.blue_level = touch_level_next;
          end
        endcase
        res_next.next_delay_ms = DELAY_TOUCH;
      end else begin
        // Glow: show the present level, then step the triangle wave.
        emit = 1'b1;
        case (glow_color)
          COLOR_RED: begin
            res_next.write_mask = MASK_RED;
            res_next.red_level  = glow_level;
          end
          COLOR_GREEN: begin
            res_next.write_mask  = MASK_GREEN;
            res_next.green_level = glow_level;
          end
          COLOR_BLUE: begin
            res_next.write_mask = MASK_BLUE;
            res_next.blue_level = glow_level;
          end
          default: res_next.write_mask = MASK_NONE;
        endcase
        res_next.next_delay_ms = DELAY_GLOW;
        if (glow_rising) begin
          step_level      = glow_level + 1'b1;
          glow_level_next = step_level;
          if (step_level >= LEVEL_FULL) begin
            glow_rising_next = 1'b0;
          end
        end else begin
          step_level      = glow_level - 1'b1;
          glow_level_next = step_level;
          if (step_level == '0) begin
            glow_rising_next = 1'b1;
            // Plain glow rotates red, green, blue after each full wave.
            if (current_mode == MODE_GLOW) begin
              glow_color_next = (glow_color >= COLOR_BLUE) ? COLOR_RED
                                                           : glow_color + 1'b1;
            end
          end
        end
      end
    end
  end

  // Effect state.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= MODE_GLOW;
      glow_level   <= '0;
      glow_rising  <= 1'b1;
      glow_color   <= COLOR_GREEN;
      touch_level  <= '0;
    end else begin
      current_mode <= current_mode_next;
      glow_level   <= glow_level_next;
      glow_rising  <= glow_rising_next;
      glow_color   <= glow_color_next;
      touch_level  <= touch_level_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/core/rgb_led_mode_effect_controller_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_led_mode_effect_controller_unit: RGB LED mode and effect controller
// Path: an accepted item is stored in the queue, then executed by the back end
// into its output register. Throughput: one item per cycle while the queue has
// room; the back end executes one queued transaction per cycle whenever its output register is free.
// Reset (synchronous): glow mode, green, level 0 rising, touch level 0,
// touch floor 10, queue and output register empty.
// ----------------------------------------------------------------------------
module rgb_led_mode_effect_controller_unit #(
  parameter int QUEUE_DEPTH = rlmec_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rlmec_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rlmec_pkg::out_item_t          out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlmec_pkg::PADDR_W-1:0] paddr,
  input  logic [rlmec_pkg::PDATA_W-1:0] pwdata,
  output logic [rlmec_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import rlmec_pkg::*;

  logic [SAMPLE_W-1:0] touch_floor;
  op_t                 front_op;
  op_t                 queue_op;
  logic                queue_valid;
  logic                queue_ready;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_floor <= TOUCH_FLOOR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOUCH_FLOOR) begin
      touch_floor <= pwdata[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TOUCH_FLOOR) begin
      prdata = {{(PDATA_W - SAMPLE_W){1'b0}}, touch_floor};
    end
  end

  // Front end: classify and scale.
  rlmec_front u_front (
    .item (in_data),
    .op   (front_op)
  );

  // Queue between front and back end.
  rlmec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_op),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_op)
  );

  // Back end: mode state and effects.
  rlmec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .touch_floor (touch_floor),
    .op_valid    (queue_valid),
    .op_ready    (queue_ready),
    .op          (queue_op),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .res         (out_data)
  );

  // Checks on the results.
  a_levels_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.red_level <= LEVEL_FULL) && (out_data.green_level <= LEVEL_FULL)
                  && (out_data.blue_level <= LEVEL_FULL))
    else $error("level above full scale");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.write_mask[0] || out_data.red_level == '0)
                  && (out_data.write_mask[1] || out_data.green_level == '0)
                  && (out_data.write_mask[2] || out_data.blue_level == '0))
    else $error("level set on a channel that is not written");

  a_mode_change_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.next_delay_ms == DELAY_MODE
      |-> out_data.write_mask == MASK_ALL && out_data.red_level == '0
          && out_data.green_level == '0 && out_data.blue_level == '0)
    else $error("mode change result does not turn all channels off");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending or queue full after reset");

endmodule

// ===== sim/rgb_led_mode_effect_controller_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_led_mode_effect_controller_unit_tb: self-checking bench for the LED
// effect controller.
// A short directed table covers the mode codes, the glow start, the touch
// floor and clamp, and the accelerometer extremes. Phases of random mode requests and
// tick runs follow, each with its own touch floor. Every result is checked against an
// in-bench predictor or a typed row. Both handshakes idle at random but in one phase.
// ----------------------------------------------------------------------------
module rgb_led_mode_effect_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlmec_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_PAUSE   = 8;
  localparam int IDLE_PCT      = 21;
  localparam int TOUCH_FULL    = 600;
  localparam int ACCEL_FULL    = 4096;
  localparam int PHASE_RESULTS = 170;
  localparam int NUM_PHASES    = 6;

  typedef struct {
    in_item_t  item;
    bit        typed;
    bit        has;
    out_item_t want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Predicted controller state and register.
  logic [MODE_W-1:0]    led_mode;
  logic [LEVEL_W-1:0]   glow_lvl;
  logic                 glow_up;
  logic [COLOR_W-1:0]   glow_chan;
  logic [LEVEL_W-1:0]   touch_lvl;
  logic [SAMPLE_W-1:0]  floor_lvl;

  out_item_t            led_expect[$];
  row_t                 directed_rows[$];
  int                   errors = 0;
  int                   cycles = 0;
  bit                   steady = 1'b0;

  rgb_led_mode_effect_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  function automatic in_item_t tick_item(input logic [15:0] touch, input logic [15:0] x,
                                         input logic [15:0] y, input logic [15:0] z);
    in_item_t it;
    it = '0;
    it.kind = KIND_TICK;
    it.touch_sample = touch;
    it.accel_x = x;
    it.accel_y = y;
    it.accel_z = z;
    return it;
  endfunction

  function automatic in_item_t mode_item(input logic [MODE_W-1:0] m);
    in_item_t it;
    it = '0;
    it.kind = KIND_MODE;
    it.new_mode = m;
    return it;
  endfunction

  function automatic out_item_t led_out(input logic [MASK_W-1:0] mask,
                                        input int r, input int g, input int b,
                                        input logic [DELAY_W-1:0] delay);
    out_item_t o;
    o.write_mask = mask;
    o.red_level = LEVEL_W'(r);
    o.green_level = LEVEL_W'(g);
    o.blue_level = LEVEL_W'(b);
    o.next_delay_ms = delay;
    return o;
  endfunction

  // Magnitude of a signed axis reading, clamped to full scale, as a percent.
  function automatic logic [LEVEL_W-1:0] accel_pct(input logic [15:0] v);
    int mag;
    mag = v[15] ? 65536 - int'(v) : int'(v);
    if (mag > ACCEL_FULL)
      mag = ACCEL_FULL;
    return LEVEL_W'(mag * int'(LEVEL_FULL) / ACCEL_FULL);
  endfunction

  // Writes one channel's level into a result; a color code past blue lights nothing.
  function automatic out_item_t light_channel(input out_item_t o,
                                              input logic [COLOR_W-1:0] chan,
                                              input logic [LEVEL_W-1:0] lvl);
    case (chan)
      COLOR_RED: begin
        o.write_mask = MASK_RED;
        o.red_level = lvl;
      end
      COLOR_GREEN: begin
        o.write_mask = MASK_GREEN;
        o.green_level = lvl;
      end
      COLOR_BLUE: begin
        o.write_mask = MASK_BLUE;
        o.blue_level = lvl;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Advances the predicted state by one transaction and returns whether a result follows.
  function automatic bit compute_led_update(input in_item_t it, output out_item_t o);
    int d;
    o = '0;
    if (it.kind == KIND_MODE) begin
      if (it.new_mode == led_mode)
        return 1'b0;
      o.write_mask = MASK_ALL;
      o.next_delay_ms = DELAY_MODE;
      if (it.new_mode <= MODE_GLOW_B) begin
        glow_lvl = '0;
        glow_up = 1'b1;
        glow_chan = (it.new_mode == MODE_GLOW) ? COLOR_GREEN : COLOR_W'(it.new_mode - 1);
        led_mode = it.new_mode;
      end else if (it.new_mode <= MODE_TOUCH_B) begin
        touch_lvl = TOUCH_PRESET;
        led_mode = it.new_mode;
      end else if (it.new_mode == MODE_ACCEL) begin
        led_mode = it.new_mode;
      end
      return 1'b1;
    end

    if (led_mode == MODE_ACCEL) begin
      o.write_mask = MASK_ALL;
      o.red_level = accel_pct(it.accel_x);
      o.green_level = accel_pct(it.accel_y);
      o.blue_level = accel_pct(it.accel_z);
      o.next_delay_ms = DELAY_ACCEL;
    end else if (led_mode >= MODE_TOUCH && led_mode <= MODE_TOUCH_B) begin
      // Samples at or below the floor hold the previous level.
      d = int'(it.touch_sample);
      if (d > int'(floor_lvl)) begin
        if (d > TOUCH_FULL)
          d = TOUCH_FULL;
        touch_lvl = LEVEL_W'(d * int'(LEVEL_FULL) / TOUCH_FULL);
      end
      case (led_mode)
        MODE_TOUCH_R: o = light_channel(o, COLOR_RED, touch_lvl);
        MODE_TOUCH_G: o = light_channel(o, COLOR_GREEN, touch_lvl);
        default:      o = light_channel(o, COLOR_BLUE, touch_lvl);
      endcase
      o.next_delay_ms = DELAY_TOUCH;
    end else begin
      // Triangle wave; plain glow moves to the next color after each full wave.
      o = light_channel(o, glow_chan, glow_lvl);
      if (glow_up) begin
        glow_lvl = glow_lvl + 1'b1;
        if (glow_lvl >= LEVEL_FULL)
          glow_up = 1'b0;
      end else begin
        glow_lvl = glow_lvl - 1'b1;
        if (glow_lvl == '0) begin
          glow_up = 1'b1;
          if (led_mode == MODE_GLOW)
            glow_chan = (glow_chan >= COLOR_BLUE) ? COLOR_RED : glow_chan + 1'b1;
        end
      end
      o.next_delay_ms = DELAY_GLOW;
    end
    return 1'b1;
  endfunction

  // Presents one transaction, with random idle cycles before it outside the steady phase, until accepted.
  task automatic send_item(input in_item_t it);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drive_and_predict(input in_item_t it, output bit has);
    out_item_t o;
    send_item(it);
    has = compute_led_update(it, o);
    if (has)
      led_expect.push_back(o);
  endtask

  task automatic add_row(input in_item_t it, input bit typed, input bit has = 1'b0,
                         input out_item_t want = '0);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.has = has;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  // Stops input, lets every expected result drain, then allows the block to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (led_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Configuration write: setup cycle, then access cycle until pready; then read it back.
  task automatic write_floor(input logic [SAMPLE_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TOUCH_FLOOR, 2'b00};
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    floor_lvl = v;
    @(posedge clk);
    check_field("prdata", int'(prdata), int'(v));
  endtask

  function automatic logic [15:0] random_axis();
    logic [15:0] corners[8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h1000,
                                16'hF000, 16'hFFFF, 16'h8001, 16'hEFFF};
    case ($urandom_range(0, 3))
      0:       return corners[$urandom_range(0, 7)];
      1:       return 16'($urandom_range(0, 10000) - 5000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: checks each accepted transaction and stalls at random outside the steady phase.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && out_ready) begin
        if (led_expect.size() == 0) begin
          report_error($sformatf("result with nothing expected, mask %0d",
                                 out_data.write_mask));
        end else begin
          check_field("write_mask", out_data.write_mask, led_expect[0].write_mask);
          check_field("red_level", out_data.red_level, led_expect[0].red_level);
          check_field("green_level", out_data.green_level, led_expect[0].green_level);
          check_field("blue_level", out_data.blue_level, led_expect[0].blue_level);
          check_field("next_delay_ms", out_data.next_delay_ms,
                      led_expect[0].next_delay_ms);
          void'(led_expect.pop_front());
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Stimulus.
  initial begin
    out_item_t        all_off;
    out_item_t        o;
    in_item_t         it;
    logic [95:0]      raw;
    logic [MODE_W-1:0] m;
    bit               has;
    int               made;
    int               roll;
    int               run;
    int               f;
    logic [SAMPLE_W-1:0] floor_plan[NUM_PHASES];

    floor_plan = '{16'd0, 16'hFFFF, 16'd600, 16'd601, 16'd0, 16'd10};
    led_mode = MODE_GLOW;
    glow_lvl = '0;
    glow_up = 1'b1;
    glow_chan = COLOR_GREEN;
    touch_lvl = '0;
    floor_lvl = TOUCH_FLOOR_RESET;
    all_off = led_out(MASK_ALL, 0, 0, 0, DELAY_MODE);

    // Directed table: glow start, every mode code, touch floor and clamp, accel extremes.
    add_row(tick_item(16'd0, 16'd0, 16'd0, 16'd0), 1'b1, 1'b1,
            led_out(MASK_GREEN, 0, 0, 0, DELAY_GLOW));
    add_row(tick_item(16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
    add_row(mode_item(MODE_GLOW), 1'b1, 1'b0);
    add_row(mode_item(4'd15), 1'b1, 1'b1, all_off);
    add_row(mode_item(4'd9), 1'b1, 1'b1, all_off);
    add_row(mode_item(MODE_GLOW_R), 1'b1, 1'b1, all_off);
    add_row(tick_item(16'd0, 16'd0, 16'd0, 16'd0), 1'b1, 1'b1,
            led_out(MASK_RED, 0, 0, 0, DELAY_GLOW));
    add_row(mode_item(MODE_GLOW_B), 1'b1, 1'b1, all_off);
    add_row(tick_item(16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
    add_row(mode_item(MODE_GLOW_G), 1'b1, 1'b1, all_off);
    add_row(tick_item(16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
    add_row(mode_item(MODE_TOUCH), 1'b1, 1'b1, all_off);
    add_row(tick_item(16'd0, 16'd0, 16'd0, 16'd0), 1'b1, 1'b1,
            led_out(MASK_BLUE, 0, 0, 50, DELAY_TOUCH));
    add_row(tick_item(16'd10, 16'd0, 16'd0, 16'd0), 1'b1, 1'b1,
            led_out(MASK_BLUE, 0, 0, 50, DELAY_TOUCH));
    add_row(tick_item(16'd11, 16'd0, 16'd0, 16'd0), 1'b1, 1'b1,
            led_out(MASK_BLUE, 0, 0, 1, DELAY_TOUCH));
    add_row(tick_item(16'hFFFF, 16'd0, 16'd0, 16'd0), 1'b1, 1'b1,
            led_out(MASK_BLUE, 0, 0, 100, DELAY_TOUCH));
    add_row(mode_item(MODE_TOUCH_R), 1'b1, 1'b1, all_off);
    add_row(tick_item(16'd300, 16'd0, 16'd0, 16'd0), 1'b0);
    add_row(mode_item(MODE_TOUCH_G), 1'b1, 1'b1, all_off);
    add_row(tick_item(16'd599, 16'd0, 16'd0, 16'd0), 1'b0);
    add_row(mode_item(MODE_TOUCH_B), 1'b1, 1'b1, all_off);
    add_row(tick_item(16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
    add_row(mode_item(MODE_ACCEL), 1'b1, 1'b1, all_off);
    add_row(tick_item(16'd0, 16'h8000, 16'h7FFF, 16'h0000), 1'b1, 1'b1,
            led_out(MASK_ALL, 100, 100, 0, DELAY_ACCEL));
    add_row(tick_item(16'd0, 16'h1000, 16'hF000, 16'h0FFF), 1'b0);
    add_row(tick_item(16'd0, 16'hFFFF, 16'h0001, 16'hEFFF), 1'b0);
    add_row(mode_item(MODE_ACCEL), 1'b1, 1'b0);
    add_row(mode_item(MODE_GLOW), 1'b1, 1'b1, all_off);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Rows with a typed expectation override the predictor; state still advances.
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item);
      has = compute_led_update(directed_rows[i].item, o);
      if (directed_rows[i].typed) begin
        has = directed_rows[i].has;
        o = directed_rows[i].want;
      end
      if (has)
        led_expect.push_back(o);
    end
    wait_idle();

    // Random phases, each under its own touch floor; one phase never idles.
    for (int p = 0; p < NUM_PHASES; p++) begin
      steady = (p == 2);
      write_floor((p == 4) ? SAMPLE_W'($urandom_range(0, 65535)) : floor_plan[p]);
      made = 0;
      while (made < PHASE_RESULTS) begin
        if ($urandom_range(0, 99) < 10) begin
          // Noise: any bit pattern at all.
          raw = {$urandom, $urandom, $urandom};
          it = raw[$bits(in_item_t)-1:0];
          drive_and_predict(it, has);
          made += has;
        end else begin
          // Mode request, mostly valid, sometimes invalid or repeated, then a tick run.
          roll = $urandom_range(0, 99);
          if (roll < 80)
            m = MODE_W'($urandom_range(0, 8));
          else if (roll < 92)
            m = MODE_W'($urandom_range(9, 15));
          else
            m = led_mode;
          drive_and_predict(mode_item(m), has);
          made += has;
          if (led_mode <= MODE_GLOW_B && $urandom_range(0, 5) == 0)
            run = $urandom_range(200, 450);
          else
            run = $urandom_range(1, 30);
          repeat (run) begin
            case ($urandom_range(0, 3))
              0: begin
                f = int'(floor_lvl) + int'($urandom_range(0, 4)) - 2;
                if (f < 0)
                  f = 0;
                if (f > 65535)
                  f = 65535;
              end
              1:       f = $urandom_range(0, 700);
              2:       f = $urandom_range(590, 610);
              default: f = $urandom_range(0, 65535);
            endcase
            it = tick_item(SAMPLE_W'(f), random_axis(), random_axis(), random_axis());
            it.new_mode = MODE_W'($urandom);
            drive_and_predict(it, has);
            made += has;
          end
        end
      end
      wait_idle();
    end

    steady = 1'b0;
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== rgb_led_mode_effect_controller_unit.f =====
rtl/core/rlmec_pkg.sv
rtl/core/rlmec_front.sv
rtl/core/rlmec_queue.sv
rtl/core/rlmec_back.sv
rtl/core/rgb_led_mode_effect_controller_unit.sv
sim/rgb_led_mode_effect_controller_unit_tb.sv
